// ===== design/u8u16_pkg.sv =====
package u8u16_pkg;

  // Command kinds handed from the decoder to the unit generator
  localparam logic [1:0] CMD_UNIT   = 2'd0;
  localparam logic [1:0] CMD_PAIR   = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [20:0] VALUE_MAX  = 21'h10FFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [15:0] HI_BASE    = 16'hD800;
  localparam logic [15:0] LO_BASE    = 16'hDC00;

  localparam int CMDQ_DEPTH_DEF = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] value;
    logic        last;
    logic        err;
  } cmd_t;

endpackage

// ===== design/u8u16_front.sv =====
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [1:0]  bn_r, bn_nxt;
  logic [20:0] pv_r, pv_nxt;
  logic        drop_r, drop_nxt;

  logic [1:0]  bn_new;
  logic [20:0] pv_new;
  logic [20:0] cont;
  logic        bad;
  logic        fail;
  logic        emit;

  always_comb begin
    bn_new = 2'd0;
    pv_new = 21'd0;
    bad    = 1'b0;
    cont   = {13'd0, data_byte ^ 8'h80};
    if (bn_r == 2'd0) begin
      if (!data_byte[7]) begin
        pv_new = {13'd0, data_byte};
        bn_new = 2'd0;
      end else if (data_byte[7:5] == 3'b110) begin
        pv_new = {10'd0, data_byte[4:0], 6'd0};
        bn_new = 2'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        pv_new = {5'd0, data_byte[3:0], 12'd0};
        bn_new = 2'd2;
      end else if (data_byte[7:3] == 5'b11110) begin
        pv_new = {data_byte[2:0], 18'd0};
        bn_new = 2'd3;
      end else begin
        bad = 1'b1;
      end
    end else begin
      case (bn_r)
        2'd1:    pv_new = pv_r | cont;
        2'd2:    pv_new = pv_r | (cont << 6);
        default: pv_new = pv_r | (cont << 12);
      endcase
      bn_new = bn_r - 2'd1;
    end
  end

  always_comb begin
    bn_nxt    = bn_r;
    pv_nxt    = pv_r;
    drop_nxt  = drop_r;
    fail      = 1'b0;
    emit      = 1'b0;
    cmd.kind  = CMD_STATUS;
    cmd.value = pv_new;
    cmd.last  = last_byte;
    cmd.err   = 1'b0;
    if (drop_r) begin
      emit = last_byte;
    end else if (bad) begin
      fail = 1'b1;
    end else if (bn_new != 2'd0) begin
      bn_nxt = bn_new;
      pv_nxt = pv_new;
      fail   = last_byte;
    end else begin
      bn_nxt = 2'd0;
      pv_nxt = 21'd0;
      if (pv_new == 21'd0) begin
        // zero value ends the text quietly
        emit     = last_byte;
        drop_nxt = 1'b1;
      end else if (pv_new > VALUE_MAX) begin
        fail = 1'b1;
      end else if (pv_new < SUPP_BASE) begin
        emit     = 1'b1;
        cmd.kind = CMD_UNIT;
      end else begin
        emit     = 1'b1;
        cmd.kind = CMD_PAIR;
      end
    end
    if (fail) begin
      emit     = 1'b1;
      cmd.kind = CMD_STATUS;
      cmd.err  = 1'b1;
      bn_nxt   = 2'd0;
      pv_nxt   = 21'd0;
      drop_nxt = 1'b1;
    end
    if (last_byte) begin
      bn_nxt   = 2'd0;
      pv_nxt   = 21'd0;
      drop_nxt = 1'b0;
    end
  end

  assign cmd_push = accept & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bn_r   <= 2'd0;
      pv_r   <= 21'd0;
      drop_r <= 1'b0;
    end else if (accept) begin
      bn_r   <= bn_nxt;
      pv_r   <= pv_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ===== design/u8u16_cmdq.sv =====
module u8u16_cmdq
  import u8u16_pkg::*;
#(
  parameter int DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== design/u8u16_back.sv =====
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_avail,
  input  cmd_t        cmd,
  output logic        cmd_pop,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [15:0] out_code_unit,
  output logic        out_unit_valid,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic        out_error
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        uval_r, uval_nxt;
  logic        rlast_r, rlast_nxt;
  logic        send_r, send_nxt;
  logic        err_r, err_nxt;
  logic        advance;
  logic [19:0] t;

  assign t       = 20'(cmd.value - SUPP_BASE);
  assign advance = ~valid_r | out_pop;

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    unit_nxt  = unit_r;
    uval_nxt  = uval_r;
    rlast_nxt = rlast_r;
    send_nxt  = send_r;
    err_nxt   = err_r;
    cmd_pop   = 1'b0;
    if (advance) begin
      valid_nxt = cmd_avail;
      if (cmd_avail) begin
        case (cmd.kind)
          CMD_UNIT: begin
            unit_nxt  = cmd.value[15:0];
            uval_nxt  = 1'b1;
            rlast_nxt = 1'b1;
            send_nxt  = cmd.last;
            err_nxt   = 1'b0;
            cmd_pop   = 1'b1;
          end
          CMD_PAIR: begin
            uval_nxt = 1'b1;
            err_nxt  = 1'b0;
            if (!phase_r) begin
              unit_nxt  = HI_BASE + {6'd0, t[19:10]};
              rlast_nxt = 1'b0;
              send_nxt  = 1'b0;
              phase_nxt = 1'b1;
            end else begin
              unit_nxt  = LO_BASE + {6'd0, t[9:0]};
              rlast_nxt = 1'b1;
              send_nxt  = cmd.last;
              phase_nxt = 1'b0;
              cmd_pop   = 1'b1;
            end
          end
          default: begin
            unit_nxt  = 16'd0;
            uval_nxt  = 1'b0;
            rlast_nxt = 1'b1;
            send_nxt  = cmd.last;
            err_nxt   = cmd.err;
            cmd_pop   = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unit_r  <= unit_nxt;
    uval_r  <= uval_nxt;
    rlast_r <= rlast_nxt;
    send_r  <= send_nxt;
    err_r   <= err_nxt;
  end

  assign out_empty      = ~valid_r;
  assign out_code_unit  = unit_r;
  assign out_unit_valid = uval_r;
  assign out_run_last   = rlast_r;
  assign out_string_end = send_r;
  assign out_error      = err_r;

endmodule

// ===== design/utf8_to_utf16_stream_transcoder_top.sv =====
// UTF-8 to UTF-16 transcoder with queue-style ports on both sides. Bytes are
// taken in one per cycle whenever in_full is low: the decoder keeps the
// sequence state and turns each byte that completes a character (or reports
// a fault or the end of the string) into a command in a queue of CMDQ_DEPTH
// entries; in_full rises only while that queue is full. The unit generator
// drains the queue into an output register and delivers one result per cycle
// while out_pop is held high and the queue is not empty, so a character outside
// the basic plane, which yields a surrogate pair, costs two output results
// against its four input bytes. A result reaches the out_ ports through the
// queue and the output register. A malformed string gives one result with
// out_error set and later bytes are dropped until last_byte, which closes the
// string with a status-only transfer (out_unit_valid low, out_string_end high).
module utf8_to_utf16_stream_transcoder_top
  import u8u16_pkg::*;
#(
  parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_code_unit,
  output logic        out_unit_valid,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic        out_error
);

  logic q_full, q_empty;
  logic cmd_push, cmd_pop;
  cmd_t cmd_in, cmd_head;
  logic in_xfer;

  // accept a byte only when the queue can take whatever it produces
  assign in_xfer = in_push & ~q_full;
  assign in_full = q_full;

  u8u16_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  u8u16_cmdq #(
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .pop      (cmd_pop),
    .head     (cmd_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // advance the queue head once its last result is loaded
  u8u16_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_avail      (~q_empty),
    .cmd            (cmd_head),
    .cmd_pop        (cmd_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_code_unit  (out_code_unit),
    .out_unit_valid (out_unit_valid),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_error      (out_error)
  );

`ifndef SYNTHESIS
  // a high surrogate is the only unit that does not end its byte's run
  a_hi_surrogate: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_run_last) |->
      (out_unit_valid && out_code_unit[15:10] == 6'b110110 && !out_string_end))
    else $error("non-final result is not a high surrogate");

  // a fault report carries no unit and ends the run
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error) |-> (!out_unit_valid && out_run_last))
    else $error("error result carries a unit");

  // string end falls only on the final result of a run
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_string_end) |-> out_run_last)
    else $error("string end on a non-final result");

  // the head command leaves the queue only when the output register takes it
  a_pop_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !out_empty)
    else $error("command dropped without a result");
`endif

endmodule
